[hw/rtl/rva_pkg.sv]
// ----------------------------------------------------------------------------
// rva_pkg
// Shared widths, constants and types of the ratiometric voltage averager.
// ----------------------------------------------------------------------------
package rva_pkg;

  localparam int HISTORY_DEPTH_DEF = 5;

  localparam int ADC_W     = 10;
  localparam int RES_W     = 16;
  localparam int TOTAL_W   = RES_W + 1;
  localparam int VCC_W     = 21;
  localparam int SAMPLE_W  = 31;
  localparam int INNER_W   = 26;
  localparam int SCALE_W   = 10;
  localparam int ADC_SHIFT = 10;
  localparam int MV_W      = 16;
  localparam int STATUS_W  = 2;
  localparam int VALUE_W   = SAMPLE_W - ADC_SHIFT + SCALE_W;

  localparam logic [VCC_W-1:0]   REF_PRODUCT = VCC_W'(1125300);
  localparam logic [SCALE_W-1:0] SCALE_NUM   = SCALE_W'(1000);
  localparam logic [MV_W-1:0]    MV_MAX      = MV_W'(65535);
  localparam logic [RES_W-1:0]   DIV_R_RESET = RES_W'(10000);

  typedef enum logic {
    REG_DIVIDER_R1 = 1'b0,
    REG_DIVIDER_R2 = 1'b1
  } reg_idx_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_SAT   = 2'd1,
    ST_EMPTY = 2'd2,
    ST_ZERO  = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_VCC,
    S_SAMPLE,
    S_INNER,
    S_SCALE,
    S_SUM,
    S_SUMCHK,
    S_AVG,
    S_SAT,
    S_DONE
  } state_t;

endpackage

[hw/rtl/ratiometric_voltage_averager_top.sv]
// ----------------------------------------------------------------------------
// ratiometric_voltage_averager_top
// Averaged battery voltage in millivolts from reference and pin ADC codes.
// ----------------------------------------------------------------------------
// Each input beat computes the supply as 1125300 / ref_reading, stores
// pin_reading times supply in a ring of HISTORY_DEPTH entries, averages the
// nonzero entries, divides by 1024 and multiplies by the divider scale
// 1000 / (r2 * 1000 / (r1 + r2)). All four divisions run on one shared
// restoring divider at one bit per cycle, and the ring is summed one entry
// per cycle. The input is not ready while an item is in progress; one
// finished result can wait in the output register while the next beat is
// accepted.
module ratiometric_voltage_averager_top #(
  parameter int HISTORY_DEPTH = rva_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [rva_pkg::RES_W-1:0]     cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [rva_pkg::ADC_W-1:0]     in_ref_reading,
  input  logic [rva_pkg::ADC_W-1:0]     in_pin_reading,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rva_pkg::MV_W-1:0]      out_battery_mv,
  output logic [rva_pkg::STATUS_W-1:0]  out_status
);

  import rva_pkg::*;

  localparam int SUM_W = SAMPLE_W + $clog2(HISTORY_DEPTH);
  localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
  localparam int IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int ITR_W = $clog2(SUM_W + 1);
  localparam int AVG_W = SAMPLE_W - ADC_SHIFT;

  state_t              state_r, state_nxt;
  logic [RES_W-1:0]    r1_r, r2_r;
  logic [ADC_W-1:0]    pin_r, pin_nxt;
  logic [VCC_W-1:0]    vcc_r, vcc_nxt;
  logic [SCALE_W-1:0]  scale_r, scale_nxt;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [VALUE_W-1:0]  value_r, value_nxt;
  logic [MV_W-1:0]     res_mv_r, res_mv_nxt;
  status_t             res_st_r, res_st_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [MV_W-1:0]     out_mv_r, out_mv_nxt;
  status_t             out_st_r, out_st_nxt;

  logic                div_start;
  logic [SUM_W-1:0]    div_dividend;
  logic [TOTAL_W-1:0]  div_divisor;
  logic [ITR_W-1:0]    div_iters;
  logic                div_done;
  logic [SUM_W-1:0]    div_quotient;

  logic                hist_we;
  logic [SAMPLE_W-1:0] hist_wdata;
  logic [SAMPLE_W-1:0] hist_rdata;

  logic [TOTAL_W-1:0]  total;
  logic [INNER_W-1:0]  inner_num;
  logic [SCALE_W-1:0]  inner_q;
  logic [AVG_W-1:0]    avg_shift;

  assign total      = {1'b0, r1_r} + {1'b0, r2_r};
  assign inner_num  = INNER_W'(r2_r) * INNER_W'(SCALE_NUM);
  assign hist_wdata = SAMPLE_W'(pin_r) * SAMPLE_W'(vcc_r);
  assign inner_q    = div_quotient[SCALE_W-1:0];
  assign avg_shift  = div_quotient[SAMPLE_W-1:ADC_SHIFT];

  rva_div #(
    .NW (SUM_W),
    .DW (TOTAL_W),
    .IW (ITR_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .iters    (div_iters),
    .done     (div_done),
    .quotient (div_quotient)
  );

  rva_hist #(
    .DEPTH (HISTORY_DEPTH),
    .W     (SAMPLE_W),
    .IDX_W (IDX_W)
  ) u_hist (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (hist_we),
    .wr_data (hist_wdata),
    .rd_idx  (idx_r),
    .rd_data (hist_rdata)
  );

  always_comb begin
    state_nxt    = state_r;
    pin_nxt      = pin_r;
    vcc_nxt      = vcc_r;
    scale_nxt    = scale_r;
    sum_nxt      = sum_r;
    cnt_nxt      = cnt_r;
    idx_nxt      = idx_r;
    value_nxt    = value_r;
    res_mv_nxt   = res_mv_r;
    res_st_nxt   = res_st_r;
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    div_iters    = '0;
    hist_we      = 1'b0;
    in_ready     = 1'b0;
    out_valid_nxt = out_valid_r & ~out_ready;
    out_mv_nxt   = out_mv_r;
    out_st_nxt   = out_st_r;

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          pin_nxt = in_pin_reading;
          if (in_ref_reading == '0) begin
            res_mv_nxt = '0;
            res_st_nxt = ST_ZERO;
            state_nxt  = S_DONE;
          end else begin
            div_start    = 1'b1;
            div_dividend = SUM_W'(REF_PRODUCT) << (SUM_W - VCC_W);
            div_divisor  = TOTAL_W'(in_ref_reading);
            div_iters    = ITR_W'(VCC_W);
            state_nxt    = S_VCC;
          end
        end
      end
      S_VCC: begin
        if (div_done) begin
          vcc_nxt   = div_quotient[VCC_W-1:0];
          state_nxt = S_SAMPLE;
        end
      end
      S_SAMPLE: begin
        hist_we = 1'b1;
        if (total == '0) begin
          res_mv_nxt = '0;
          res_st_nxt = ST_ZERO;
          state_nxt  = S_DONE;
        end else begin
          div_start    = 1'b1;
          div_dividend = SUM_W'(inner_num) << (SUM_W - INNER_W);
          div_divisor  = total;
          div_iters    = ITR_W'(INNER_W);
          state_nxt    = S_INNER;
        end
      end
      S_INNER: begin
        if (div_done) begin
          if (inner_q == '0) begin
            res_mv_nxt = '0;
            res_st_nxt = ST_ZERO;
            state_nxt  = S_DONE;
          end else begin
            div_start    = 1'b1;
            div_dividend = SUM_W'(SCALE_NUM) << (SUM_W - SCALE_W);
            div_divisor  = TOTAL_W'(inner_q);
            div_iters    = ITR_W'(SCALE_W);
            state_nxt    = S_SCALE;
          end
        end
      end
      S_SCALE: begin
        if (div_done) begin
          scale_nxt = div_quotient[SCALE_W-1:0];
          sum_nxt   = '0;
          cnt_nxt   = '0;
          idx_nxt   = '0;
          state_nxt = S_SUM;
        end
      end
      S_SUM: begin
        if (hist_rdata != '0) begin
          sum_nxt = sum_r + SUM_W'(hist_rdata);
          cnt_nxt = cnt_r + 1'b1;
        end
        if (idx_r == IDX_W'(HISTORY_DEPTH - 1)) begin
          state_nxt = S_SUMCHK;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_SUMCHK: begin
        if (cnt_r == '0) begin
          res_mv_nxt = '0;
          res_st_nxt = ST_EMPTY;
          state_nxt  = S_DONE;
        end else begin
          div_start    = 1'b1;
          div_dividend = sum_r;
          div_divisor  = TOTAL_W'(cnt_r);
          div_iters    = ITR_W'(SUM_W);
          state_nxt    = S_AVG;
        end
      end
      S_AVG: begin
        if (div_done) begin
          value_nxt = VALUE_W'(avg_shift) * VALUE_W'(scale_r);
          state_nxt = S_SAT;
        end
      end
      S_SAT: begin
        if (value_r > VALUE_W'(MV_MAX)) begin
          res_mv_nxt = MV_MAX;
          res_st_nxt = ST_SAT;
        end else begin
          res_mv_nxt = value_r[MV_W-1:0];
          res_st_nxt = ST_OK;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_mv_nxt    = res_mv_r;
          out_st_nxt    = res_st_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    pin_r    <= pin_nxt;
    vcc_r    <= vcc_nxt;
    scale_r  <= scale_nxt;
    sum_r    <= sum_nxt;
    cnt_r    <= cnt_nxt;
    idx_r    <= idx_nxt;
    value_r  <= value_nxt;
    res_mv_r <= res_mv_nxt;
    res_st_r <= res_st_nxt;
    out_mv_r <= out_mv_nxt;
    out_st_r <= out_st_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r1_r <= DIV_R_RESET;
      r2_r <= DIV_R_RESET;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_DIVIDER_R1: r1_r <= cfg_wdata;
        REG_DIVIDER_R2: r2_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_battery_mv = out_mv_r;
  assign out_status     = out_st_r;

endmodule

[hw/rtl/rva_div.sv]
// ----------------------------------------------------------------------------
// rva_div
// Iterative restoring divider, one quotient bit per cycle. The dividend is
// given left-aligned and the number of steps equals its significant width.
// ----------------------------------------------------------------------------
module rva_div #(
  parameter int NW = 34,
  parameter int DW = 17,
  parameter int IW = 6
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  input  logic [IW-1:0] iters,
  output logic          done,
  output logic [NW-1:0] quotient
);

  logic [NW-1:0] quo_r, quo_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] dvs_r, dvs_nxt;
  logic [IW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;

  assign trial = {rem_r, quo_r[NW-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign ge    = (trial >= {1'b0, dvs_r});

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = iters;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      quo_nxt = {quo_r[NW-2:0], ge};
      rem_nxt = ge ? diff[DW-1:0] : trial[DW-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == IW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

[hw/rtl/rva_hist.sv]
// ----------------------------------------------------------------------------
// rva_hist
// Sample ring with its write pointer, cleared at reset, read at one index.
// ----------------------------------------------------------------------------
module rva_hist #(
  parameter int DEPTH = 5,
  parameter int W     = 31,
  parameter int IDX_W = 3
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [W-1:0]     wr_data,
  input  logic [IDX_W-1:0] rd_idx,
  output logic [W-1:0]     rd_data
);

  logic [W-1:0]     mem_r [DEPTH];
  logic [IDX_W-1:0] wp_r, wp_nxt;

  assign wp_nxt = (wp_r == IDX_W'(DEPTH - 1)) ? '0 : wp_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      for (int i = 0; i < DEPTH; i++) begin
        mem_r[i] <= '0;
      end
    end else if (wr_en) begin
      wp_r        <= wp_nxt;
      mem_r[wp_r] <= wr_data;
    end
  end

  assign rd_data = mem_r[rd_idx];

endmodule
